>>> rtl/mse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the MIPS subset execute block.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam logic [5:0]  OPC_RTYPE   = 6'd0;
    localparam logic [5:0]  OPC_BEQ     = 6'd4;
    localparam logic [5:0]  OPC_BNE     = 6'd5;
    localparam logic [5:0]  OPC_ADDI    = 6'd8;
    localparam logic [5:0]  OPC_ANDI    = 6'd12;

    localparam logic [5:0]  FN_SLL      = 6'h00;
    localparam logic [5:0]  FN_SRL      = 6'h02;
    localparam logic [5:0]  FN_ADD      = 6'h20;

    localparam logic [31:0] START_RESET = 32'h0040_0000;
    localparam logic [31:0] PC_STEP     = 32'd4;
    localparam logic [31:0] PC_ALIGN    = 32'hffff_fffc;
    localparam logic [4:0]  REG_ZERO    = 5'd0;

    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SLL,
        CLS_SRL,
        CLS_ADDI,
        CLS_ANDI,
        CLS_BEQ,
        CLS_BNE,
        CLS_ILLEGAL
    } op_cls_t;

    typedef struct packed {
        op_cls_t     cls;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dst;
        logic [4:0]  shamt;
        logic [15:0] imm;
    } dec_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        write_enable;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic        branch_taken;
        logic        illegal;
    } exec_result_t;

endpackage : mse_pkg
`default_nettype wire

>>> rtl/mse_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_decode
// Front end: accepts instruction beats, classifies them and holds the decoded
// items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mse_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [31:0]       instr_word,
    output logic                   full,
    output logic                   q_valid,
    output mse_pkg::dec_item_t     q_item,
    input  wire logic              q_pop
);
    import mse_pkg::*;

    dec_item_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    dec_item_t   dec;
    logic [5:0]  opc;
    logic [5:0]  funct;
    logic        do_push;
    logic        do_pop;

    assign opc   = instr_word[31:26];
    assign funct = instr_word[5:0];

    always_comb
    begin
        dec.rs    = instr_word[25:21];
        dec.rt    = instr_word[20:16];
        dec.shamt = instr_word[10:6];
        dec.imm   = instr_word[15:0];
        dec.dst   = instr_word[20:16];
        dec.cls   = CLS_ILLEGAL;
        unique case (opc)
            OPC_RTYPE:
            begin
                dec.dst = instr_word[15:11];
                unique case (funct)
                    FN_ADD:  dec.cls = CLS_ADD;
                    FN_SLL:  dec.cls = CLS_SLL;
                    FN_SRL:  dec.cls = CLS_SRL;
                    default: dec.cls = CLS_ILLEGAL;
                endcase
            end
            OPC_ADDI: dec.cls = CLS_ADDI;
            OPC_ANDI: dec.cls = CLS_ANDI;
            OPC_BEQ:  dec.cls = CLS_BEQ;
            OPC_BNE:  dec.cls = CLS_BNE;
            default:  dec.cls = CLS_ILLEGAL;
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("decode queue overflow");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("decode queue lost a push");
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("decode queue lost a pop");
`endif

endmodule : mse_decode
`default_nettype wire

>>> rtl/mse_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_execute
// Back end: register read stage, then ALU, branch resolve, pc update and
// register writeback. Writes that land on the read edge are forwarded.
// ----------------------------------------------------------------------------
module mse_execute (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire mse_pkg::dec_item_t   q_item,
    output logic                      q_pop,
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_pc,
    output logic                      res_valid,
    output mse_pkg::exec_result_t     res,
    input  wire logic                 res_ready
);
    import mse_pkg::*;

    logic [31:0]  rf_mem [32];
    logic [31:0]  rf_valid_reg;
    logic [31:0]  pc_reg;

    logic         rd_valid_reg;
    dec_item_t    rd_item_reg;
    logic [31:0]  rs_data_reg, rt_data_reg;
    logic         rs_vld_reg, rt_vld_reg;
    logic         fwd_we_reg;
    logic [4:0]   fwd_idx_reg;
    logic [31:0]  fwd_val_reg;

    logic         read_fire;
    logic         exec_fire;
    logic [31:0]  op_a, op_b;
    logic [31:0]  pc_plus4;
    logic [31:0]  sext_imm;
    logic         eq;
    exec_result_t r;
    logic         we_raw;

    assign exec_fire = rd_valid_reg && res_ready;
    assign read_fire = q_valid && (!rd_valid_reg || exec_fire);
    assign q_pop     = read_fire;

    always_comb
    begin
        if (fwd_we_reg && fwd_idx_reg == rd_item_reg.rs)
        begin
            op_a = fwd_val_reg;
        end
        else
        begin
            op_a = rs_vld_reg ? rs_data_reg : 32'd0;
        end
        if (fwd_we_reg && fwd_idx_reg == rd_item_reg.rt)
        begin
            op_b = fwd_val_reg;
        end
        else
        begin
            op_b = rt_vld_reg ? rt_data_reg : 32'd0;
        end
    end

    assign pc_plus4 = pc_reg + PC_STEP;
    assign sext_imm = {{16{rd_item_reg.imm[15]}}, rd_item_reg.imm};
    assign eq       = (op_a == op_b);

    always_comb
    begin
        r.next_pc      = pc_plus4;
        r.write_index  = rd_item_reg.dst;
        r.write_value  = 32'd0;
        r.branch_taken = 1'b0;
        r.illegal      = 1'b0;
        we_raw         = 1'b0;
        unique case (rd_item_reg.cls)
            CLS_ADD:
            begin
                we_raw        = 1'b1;
                r.write_value = op_a + op_b;
            end
            CLS_SLL:
            begin
                we_raw        = 1'b1;
                r.write_value = op_b << rd_item_reg.shamt;
            end
            CLS_SRL:
            begin
                we_raw        = 1'b1;
                r.write_value = op_b >> rd_item_reg.shamt;
            end
            CLS_ADDI:
            begin
                we_raw        = 1'b1;
                r.write_value = op_a + sext_imm;
            end
            CLS_ANDI:
            begin
                we_raw        = 1'b1;
                r.write_value = op_a & {16'd0, rd_item_reg.imm};
            end
            CLS_BEQ, CLS_BNE:
            begin
                r.branch_taken = (rd_item_reg.cls == CLS_BEQ) ? eq : !eq;
                if (r.branch_taken)
                begin
                    r.next_pc = pc_plus4 + {sext_imm[29:0], 2'b00};
                end
            end
            CLS_ILLEGAL:
            begin
                r.illegal = 1'b1;
                r.next_pc = pc_reg;
            end
        endcase
        r.write_enable = we_raw && (rd_item_reg.dst != REG_ZERO);
        if (!r.write_enable)
        begin
            r.write_index = REG_ZERO;
            r.write_value = 32'd0;
        end
    end

    assign res       = r;
    assign res_valid = rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= START_RESET;
            rf_valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_item_reg  <= '0;
            fwd_we_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_pc & PC_ALIGN;
            end
            else if (exec_fire)
            begin
                pc_reg <= r.next_pc;
            end
            if (exec_fire && r.write_enable)
            begin
                rf_valid_reg[r.write_index] <= 1'b1;
            end
            if (read_fire)
            begin
                rd_valid_reg <= 1'b1;
                rd_item_reg  <= q_item;
                fwd_we_reg   <= exec_fire && r.write_enable;
            end
            else if (exec_fire)
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire && r.write_enable)
        begin
            rf_mem[r.write_index] <= r.write_value;
        end
        if (read_fire)
        begin
            rs_data_reg <= rf_mem[q_item.rs];
            rt_data_reg <= rf_mem[q_item.rt];
            rs_vld_reg  <= rf_valid_reg[q_item.rs];
            rt_vld_reg  <= rf_valid_reg[q_item.rt];
            fwd_idx_reg <= r.write_index;
            fwd_val_reg <= r.write_value;
        end
    end

`ifndef SYNTHESIS
    a_zero_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("register zero marked written");
    a_illegal_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && r.illegal && !cfg_we) |=> (pc_reg == $past(pc_reg)))
        else $error("illegal beat moved the pc");
    a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && r.illegal) |-> (!r.write_enable && !r.branch_taken))
        else $error("illegal beat has side effects");
    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && !res_ready) |=> rd_valid_reg)
        else $error("read stage dropped a stalled beat");
`endif

endmodule : mse_execute
`default_nettype wire

>>> rtl/mse_result_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_result_q
// Two-entry result queue between the execute stage and the result channel.
// ----------------------------------------------------------------------------
module mse_result_q (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   res_valid,
    input  wire mse_pkg::exec_result_t  res,
    output logic                        res_ready,
    output logic                        empty,
    input  wire logic                   pop,
    output mse_pkg::exec_result_t       head
);
    import mse_pkg::*;

    exec_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign res_ready = (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = res_valid && res_ready;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overflow");
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> !empty)
        else $error("pushed result not visible");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("result queue pointers out of step");
`endif

endmodule : mse_result_q
`default_nettype wire

>>> rtl/mips_subset_execute_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_top
// Executes add, addi, andi, sll, srl, beq and bne against a 32-entry register
// file and a program counter, one instruction word per beat.
//
// Input channel: push/full with instr_word; a beat is taken when push is high
// and full is low. Result channel: empty/pop; the oldest result sits on
// next_pc, write_enable, write_index, write_value, branch_taken and illegal
// while empty is low, and leaves on a clock edge with pop high.
// Config channel: cfg_valid/cfg_ready/cfg_data loads start_address (low two
// bits cleared) straight into the pc; cfg_ready is always high. Write it only
// while the block is idle.
// A beat passes the decode queue, read stage and result queue before its result
// is visible. Throughput: one beat per cycle unless the result side stalls, set
// by the execute/writeback stage with forwarding of same-cycle register writes.
// Reset: registers read as zero, pc = 0x00400000, both queues empty.
// A stalled result side fills the 2-entry result queue, then the read stage,
// then the 2-entry decode queue, after which full rises.
// ----------------------------------------------------------------------------
module mips_subset_execute_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] instr_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      next_pc,
    output logic             write_enable,
    output logic [4:0]       write_index,
    output logic [31:0]      write_value,
    output logic             branch_taken,
    output logic             illegal,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import mse_pkg::*;

    logic          q_valid;
    dec_item_t     q_item;
    logic          q_pop;
    logic          res_valid;
    exec_result_t  res;
    logic          res_ready;
    exec_result_t  head;

    assign cfg_ready = 1'b1;

    mse_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .instr_word (instr_word),
        .full       (full),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    mse_execute u_execute (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_pc     (cfg_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    mse_result_q u_result_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready),
        .empty      (empty),
        .pop        (pop),
        .head       (head)
    );

    assign next_pc      = head.next_pc;
    assign write_enable = head.write_enable;
    assign write_index  = head.write_index;
    assign write_value  = head.write_value;
    assign branch_taken = head.branch_taken;
    assign illegal      = head.illegal;

endmodule : mips_subset_execute_top
`default_nettype wire
